// ----- rtl/core/periodic_rectangle_grid_placer_assert.svh -----
// Assertion macros for the periodic rectangle grid placer.
// Used by the controller; needs nothing else.
`ifndef PERIODIC_RECTANGLE_GRID_PLACER_ASSERT_SVH
`define PERIODIC_RECTANGLE_GRID_PLACER_ASSERT_SVH
// same-cycle implication
`define PRGP_ASSERT_IMP(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) else $error(msg);
// next-cycle implication
`define PRGP_ASSERT_NXT(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) else $error(msg);
`endif

// ----- rtl/core/prgp_pkg.sv -----
// Package for the periodic rectangle grid placer: sizes, status codes and the
// command/status structs between controller and datapath. No dependencies.
`default_nettype none
package prgp_pkg;
  localparam int MAX_SLOTS  = 256;
  localparam int MAX_PILOTS = 64;
  localparam int SLOT_AW    = $clog2(MAX_SLOTS);
  localparam int CFG_S_W    = 9;
  localparam int CFG_P_W    = 7;
  localparam int POS_W      = 10;
  localparam int W_W        = 10;
  localparam int SPAN_W     = 18;
  localparam int BND_W      = SPAN_W + 1;
  localparam int NUM_W      = 16;
  localparam int TOP_W      = NUM_W + 1;

  typedef enum logic [1:0] {
    ST_PLACED  = 2'd0,
    ST_NOROOM  = 2'd1,
    ST_SKIPPED = 2'd2,
    ST_CLEARED = 2'd3
  } status_t;

  typedef struct packed {
    logic    load;
    logic    setup;
    logic    clr_step;
    logic    div_go;
    logic    w_init;
    logic    w_inc;
    logic    b_init;
    logic    b_inc;
    logic    o_init;
    logic    o_dec;
    logic    scan_init;
    logic    mark_init;
    logic    scan_adv;
    logic    rd;
    logic    mark_wr;
    logic    record;
    logic    set_halt;
    logic    clr_halt;
    logic    resp;
    status_t code;
  } prgp_cmd_t;

  typedef struct packed {
    logic halted;
    logic bad_item;
    logic div_done;
    logic w_over;
    logic row_stop;
    logic h_zero;
    logic bound_fail;
    logic o_last;
    logic hit;
    logic scan_last;
    logic found;
    logic best_h_zero;
    logic clr_last;
  } prgp_sts_t;
endpackage
`default_nettype wire

// ----- rtl/core/periodic_rectangle_grid_placer.sv -----
// Periodic rectangle grid placer: one transaction in, one result strobe out.
// A clear item sweeps the whole grid; a skipped item goes straight to the response. A place
// item divides and steps for each width tried, tries bottom rows and candidate offsets,
// reads grid columns, then marks the chosen columns. Next transaction taken in the strobe cycle.
// Reset: clearing pass over all 256 grid columns with busy high; receiver cannot stall.
// Depends on prgp_pkg, prgp_ctrl, prgp_dp.
`default_nettype none
module periodic_rectangle_grid_placer
  import prgp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic        in_kind,
  input  wire logic [7:0]  in_flow_offset,
  input  wire logic [8:0]  in_flow_period,
  input  wire logic [8:0]  in_flow_latency,
  input  wire logic [14:0] in_flow_payload,
  input  wire logic [8:0]  in_packet_count,
  input  wire logic [7:0]  in_flow_id,
  output logic             out_valid,
  output logic [1:0]       out_status,
  output logic [7:0]       out_left_slot,
  output logic [7:0]       out_right_slot,
  output logic [5:0]       out_bottom_row,
  output logic [6:0]       out_rect_height,
  output logic [7:0]       out_echo_flow_id,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  logic [CFG_S_W-1:0] slots_r;
  logic [CFG_P_W-1:0] pilots_r;
  prgp_cmd_t          cmd;
  prgp_sts_t          sts;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slots_r  <= CFG_S_W'(256);
      pilots_r <= CFG_P_W'(64);
    end else if (psel && penable && pwrite) begin
      if (paddr[2]) pilots_r <= pwdata[CFG_P_W-1:0];
      else          slots_r  <= pwdata[CFG_S_W-1:0];
    end
  end

  assign prdata = paddr[2] ? 32'(pilots_r) : 32'(slots_r);

  prgp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .in_kind  (in_kind),
    .busy     (busy),
    .out_valid(out_valid),
    .cmd      (cmd),
    .sts      (sts)
  );

  prgp_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .slots_cfg       (slots_r),
    .pilots_cfg      (pilots_r),
    .in_flow_offset  (in_flow_offset),
    .in_flow_period  (in_flow_period),
    .in_flow_latency (in_flow_latency),
    .in_flow_payload (in_flow_payload),
    .in_packet_count (in_packet_count),
    .in_flow_id      (in_flow_id),
    .out_status      (out_status),
    .out_left_slot   (out_left_slot),
    .out_right_slot  (out_right_slot),
    .out_bottom_row  (out_bottom_row),
    .out_rect_height (out_rect_height),
    .out_echo_flow_id(out_echo_flow_id)
  );
endmodule
`default_nettype wire

// ----- rtl/core/prgp_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module prgp_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule
`default_nettype wire

// ----- rtl/core/prgp_div.sv -----
// Restoring divider, one quotient bit per cycle, for the rectangle height.
// Depends on prgp_pkg.
`default_nettype none
module prgp_div
  import prgp_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             go,
  input  wire logic [NUM_W-1:0] num,
  input  wire logic [8:0]       den,
  output logic                  done,
  output logic [NUM_W-1:0]      quo
);
  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] n_r, n_nxt, q_r, q_nxt;
  logic [8:0]       rem_r, rem_nxt;
  logic [9:0]       sh;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             run_r, run_nxt, done_r, done_nxt;

  always_comb begin
    n_nxt    = n_r;
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    run_nxt  = run_r;
    done_nxt = 1'b0;
    sh       = {rem_r, n_r[NUM_W-1]};
    if (go) begin
      n_nxt   = num;
      q_nxt   = '0;
      rem_nxt = '0;
      cnt_nxt = '0;
      run_nxt = 1'b1;
    end else if (run_r) begin
      n_nxt = {n_r[NUM_W-2:0], 1'b0};
      if (sh >= {1'b0, den}) begin
        rem_nxt = 9'(sh - {1'b0, den});
        q_nxt   = {q_r[NUM_W-2:0], 1'b1};
      end else begin
        rem_nxt = sh[8:0];
        q_nxt   = {q_r[NUM_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(NUM_W - 1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    n_r   <= n_nxt;
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    cnt_r <= cnt_nxt;
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
    end
  end

  assign done = done_r;
  assign quo  = q_r;
endmodule
`default_nettype wire

// ----- rtl/core/prgp_dp.sv -----
// Datapath of the placer: item registers, search counters, grid RAM, divider
// and result registers. Depends on prgp_pkg, prgp_ram, prgp_div.
`default_nettype none
module prgp_dp
  import prgp_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire prgp_cmd_t          cmd,
  output prgp_sts_t               sts,
  input  wire logic [CFG_S_W-1:0] slots_cfg,
  input  wire logic [CFG_P_W-1:0] pilots_cfg,
  input  wire logic [7:0]         in_flow_offset,
  input  wire logic [8:0]         in_flow_period,
  input  wire logic [8:0]         in_flow_latency,
  input  wire logic [14:0]        in_flow_payload,
  input  wire logic [8:0]         in_packet_count,
  input  wire logic [7:0]         in_flow_id,
  output logic [1:0]              out_status,
  output logic [7:0]              out_left_slot,
  output logic [7:0]              out_right_slot,
  output logic [5:0]              out_bottom_row,
  output logic [6:0]              out_rect_height,
  output logic [7:0]              out_echo_flow_id
);
  logic [7:0]  offset_r, id_r;
  logic [8:0]  period_r, latency_r, count_r, copies_r, k_r;
  logic [14:0] payload_r;
  logic [8:0]  copies;
  logic [SPAN_W-1:0] span_r;
  logic [W_W-1:0]    wmax_r, w_r, c_r, sw_r;
  logic [NUM_W-1:0]  hgt_r, quo;
  logic [CFG_P_W-1:0] b_r, p_eff, best_b_r, best_h_r;
  logic [CFG_S_W-1:0] s_eff;
  logic [POS_W-1:0]   o_r, best_left_r;
  logic [W_W-1:0]     best_w_r;
  logic [TOP_W-1:0]   top, best_top_r;
  logic [MAX_PILOTS-1:0] mask, mask_r, best_mask_r, smask_r, rdata, wdata;
  logic [BND_W-1:0]   l_r, col, bnd;
  logic [SLOT_AW-1:0] clr_cnt_r, waddr;
  logic               halted_r, found_r, div_done, we;
  logic [POS_W-1:0]   right;

  assign s_eff = (int'(slots_cfg) > MAX_SLOTS) ? CFG_S_W'(MAX_SLOTS) : slots_cfg;
  assign p_eff = (int'(pilots_cfg) > MAX_PILOTS) ? CFG_P_W'(MAX_PILOTS) : pilots_cfg;
  assign copies = (period_r == '0 && count_r != '0) ? 9'd1 : count_r;
  assign top = TOP_W'(hgt_r) + TOP_W'(b_r);
  assign bnd = BND_W'(o_r) + BND_W'(w_r) + BND_W'(span_r);
  assign col = l_r + BND_W'(c_r);

  always_comb begin
    for (int i = 0; i < MAX_PILOTS; i++) begin
      mask[i] = (TOP_W'(i) >= TOP_W'(b_r)) && (TOP_W'(i) < top);
    end
  end

  prgp_div u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .go   (cmd.div_go),
    .num  (NUM_W'(payload_r) + NUM_W'(w_r) - 1'b1),
    .den  (w_r[8:0]),
    .done (div_done),
    .quo  (quo)
  );

  assign we    = cmd.clr_step | cmd.mark_wr;
  assign waddr = cmd.clr_step ? clr_cnt_r : col[SLOT_AW-1:0];
  assign wdata = cmd.clr_step ? '0 : (rdata | smask_r);

  prgp_ram #(.WIDTH(MAX_PILOTS), .DEPTH(MAX_SLOTS)) u_grid (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .re   (cmd.rd),
    .raddr(col[SLOT_AW-1:0]),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      offset_r  <= in_flow_offset;
      period_r  <= in_flow_period;
      latency_r <= in_flow_latency;
      payload_r <= in_flow_payload;
      count_r   <= in_packet_count;
      id_r      <= in_flow_id;
    end
    if (cmd.setup) begin
      copies_r <= copies;
      span_r   <= period_r * (copies - 9'd1);
      wmax_r   <= (payload_r <= 15'(latency_r) && payload_r != '0) ?
                  W_W'(payload_r) : W_W'(latency_r);
    end
    if (cmd.w_init) w_r <= W_W'(1);
    else if (cmd.w_inc) w_r <= w_r + 1'b1;
    if (div_done) hgt_r <= quo;
    if (cmd.b_init) b_r <= '0;
    else if (cmd.b_inc) b_r <= b_r + 1'b1;
    if (cmd.o_init) begin
      o_r    <= POS_W'(offset_r) + POS_W'(latency_r) - POS_W'(w_r);
      mask_r <= mask;
    end else if (cmd.o_dec) begin
      o_r <= o_r - 1'b1;
    end
    if (cmd.scan_init) begin
      l_r     <= BND_W'(o_r);
      k_r     <= '0;
      c_r     <= '0;
      sw_r    <= w_r;
      smask_r <= mask_r;
    end else if (cmd.mark_init) begin
      l_r     <= BND_W'(best_left_r);
      k_r     <= '0;
      c_r     <= '0;
      sw_r    <= best_w_r;
      smask_r <= best_mask_r;
    end else if (cmd.scan_adv) begin
      if (c_r == sw_r - 1'b1) begin
        c_r <= '0;
        k_r <= k_r + 1'b1;
        l_r <= l_r + BND_W'(period_r);
      end else begin
        c_r <= c_r + 1'b1;
      end
    end
    if (cmd.record) begin
      best_left_r <= o_r;
      best_w_r    <= w_r;
      best_b_r    <= b_r;
      best_h_r    <= CFG_P_W'(hgt_r);
      best_top_r  <= top;
      best_mask_r <= mask_r;
    end
    if (cmd.resp) begin
      out_status       <= cmd.code;
      out_echo_flow_id <= id_r;
      if (cmd.code == ST_PLACED) begin
        out_left_slot   <= best_left_r[7:0];
        out_right_slot  <= right[7:0];
        out_bottom_row  <= best_b_r[5:0];
        out_rect_height <= best_h_r;
      end else begin
        out_left_slot   <= '0;
        out_right_slot  <= '0;
        out_bottom_row  <= '0;
        out_rect_height <= '0;
      end
    end
  end

  assign right = best_left_r + POS_W'(best_w_r) - 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      halted_r  <= 1'b0;
      found_r   <= 1'b0;
      clr_cnt_r <= '0;
    end else begin
      if (cmd.set_halt) halted_r <= 1'b1;
      else if (cmd.clr_halt) halted_r <= 1'b0;
      if (cmd.setup) found_r <= 1'b0;
      else if (cmd.record) found_r <= 1'b1;
      if (cmd.clr_step) clr_cnt_r <= clr_cnt_r + 1'b1;
    end
  end

  always_comb begin
    sts.halted      = halted_r;
    sts.bad_item    = (latency_r == '0) || (count_r == '0);
    sts.div_done    = div_done;
    sts.w_over      = w_r > wmax_r;
    sts.row_stop    = (b_r >= p_eff) ||
                      (hgt_r != '0 && top > TOP_W'(p_eff)) ||
                      (found_r && top >= best_top_r);
    sts.h_zero      = hgt_r == '0;
    sts.bound_fail  = bnd > BND_W'(s_eff);
    sts.o_last      = o_r == POS_W'(offset_r);
    sts.hit         = |(rdata & smask_r);
    sts.scan_last   = (k_r == copies_r - 1'b1) && (c_r == sw_r - 1'b1);
    sts.found       = found_r;
    sts.best_h_zero = best_h_r == '0;
    sts.clr_last    = clr_cnt_r == SLOT_AW'(MAX_SLOTS - 1);
  end
endmodule
`default_nettype wire

// ----- rtl/core/prgp_ctrl.sv -----
// Controller of the placer: sequences clear sweeps, the width/bottom/offset
// search, column scans and marking. Depends on prgp_pkg and the assert header.
`default_nettype none
`include "periodic_rectangle_grid_placer_assert.svh"
module prgp_ctrl
  import prgp_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      start,
  input  wire logic      in_kind,
  output logic           busy,
  output logic           out_valid,
  output prgp_cmd_t      cmd,
  input  wire prgp_sts_t sts
);
  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_SETUP, S_CHECK, S_DIVGO, S_DIVW, S_ROW, S_NEXTW,
    S_OCHK, S_CRD, S_CCK, S_FIN, S_MRD, S_MWR, S_RESP
  } state_t;

  state_t  state_r, state_nxt;
  status_t code_r, code_nxt;
  logic    clr_item_r, clr_item_nxt, out_valid_r;

  always_comb begin
    state_nxt    = state_r;
    code_nxt     = code_r;
    clr_item_nxt = clr_item_r;
    cmd          = '0;
    cmd.code     = code_r;
    unique case (state_r)
      S_CLR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) begin
          if (clr_item_r) begin
            cmd.clr_halt = 1'b1;
            code_nxt     = ST_CLEARED;
            state_nxt    = S_RESP;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          if (!in_kind) begin
            clr_item_nxt = 1'b1;
            state_nxt    = S_CLR;
          end else if (sts.halted) begin
            code_nxt  = ST_SKIPPED;
            state_nxt = S_RESP;
          end else begin
            state_nxt = S_SETUP;
          end
        end
      end
      S_SETUP: begin
        cmd.setup  = 1'b1;
        cmd.w_init = 1'b1;
        state_nxt  = S_CHECK;
      end
      S_CHECK: state_nxt = sts.bad_item ? S_FIN : S_DIVGO;
      S_DIVGO: begin
        cmd.div_go = 1'b1;
        state_nxt  = S_DIVW;
      end
      S_DIVW: begin
        if (sts.div_done) begin
          cmd.b_init = 1'b1;
          state_nxt  = S_ROW;
        end
      end
      S_ROW: begin
        if (sts.row_stop) begin
          cmd.w_inc = 1'b1;
          state_nxt = S_NEXTW;
        end else begin
          cmd.o_init = 1'b1;
          state_nxt  = S_OCHK;
        end
      end
      S_NEXTW: state_nxt = sts.w_over ? S_FIN : S_DIVGO;
      S_OCHK: begin
        priority if (sts.h_zero) begin
          cmd.record = 1'b1;
          cmd.w_inc  = 1'b1;
          state_nxt  = S_NEXTW;
        end else if (sts.bound_fail) begin
          if (sts.o_last) begin
            cmd.b_inc = 1'b1;
            state_nxt = S_ROW;
          end else begin
            cmd.o_dec = 1'b1;
          end
        end else begin
          cmd.scan_init = 1'b1;
          state_nxt     = S_CRD;
        end
      end
      S_CRD: begin
        cmd.rd    = 1'b1;
        state_nxt = S_CCK;
      end
      S_CCK: begin
        priority if (sts.hit) begin
          if (sts.o_last) begin
            cmd.b_inc = 1'b1;
            state_nxt = S_ROW;
          end else begin
            cmd.o_dec = 1'b1;
            state_nxt = S_OCHK;
          end
        end else if (sts.scan_last) begin
          cmd.record = 1'b1;
          cmd.w_inc  = 1'b1;
          state_nxt  = S_NEXTW;
        end else begin
          cmd.scan_adv = 1'b1;
          state_nxt    = S_CRD;
        end
      end
      S_FIN: begin
        priority if (!sts.found) begin
          cmd.set_halt = 1'b1;
          code_nxt     = ST_NOROOM;
          state_nxt    = S_RESP;
        end else if (sts.best_h_zero) begin
          code_nxt  = ST_PLACED;
          state_nxt = S_RESP;
        end else begin
          cmd.mark_init = 1'b1;
          state_nxt     = S_MRD;
        end
      end
      S_MRD: begin
        cmd.rd    = 1'b1;
        state_nxt = S_MWR;
      end
      S_MWR: begin
        cmd.mark_wr = 1'b1;
        if (sts.scan_last) begin
          code_nxt  = ST_PLACED;
          state_nxt = S_RESP;
        end else begin
          cmd.scan_adv = 1'b1;
          state_nxt    = S_MRD;
        end
      end
      S_RESP: begin
        cmd.resp     = 1'b1;
        clr_item_nxt = 1'b0;
        state_nxt    = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      code_r      <= ST_PLACED;
      clr_item_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      code_r      <= code_nxt;
      clr_item_r  <= clr_item_nxt;
      out_valid_r <= state_r == S_RESP;
    end
  end

  assign busy      = state_r != S_IDLE;
  assign out_valid = out_valid_r;

  `PRGP_ASSERT_NXT(a_accept_busy, clk, rst_n, start && !busy, busy, "busy not raised")
  `PRGP_ASSERT_NXT(a_one_strobe, clk, rst_n, out_valid, !out_valid, "strobe held")
  `PRGP_ASSERT_IMP(a_strobe_idle, clk, rst_n, out_valid, !busy, "result while busy")
endmodule
`default_nettype wire

// ----- tb/periodic_rectangle_grid_placer_tb.sv -----
// Testbench for the periodic rectangle grid placer: directed and random flows,
// checked against a placement predictor kept in the bench.
// Depends on prgp_pkg and periodic_rectangle_grid_placer.
`timescale 1ns / 1ps
`default_nettype none
module periodic_rectangle_grid_placer_tb
  import prgp_pkg::*;
();

  localparam logic [2:0] ADDR_SLOTS  = 3'd0;
  localparam logic [2:0] ADDR_PILOTS = 3'd4;
  localparam int NO_TOP = 99999;

  typedef struct {
    logic        kind;
    logic [7:0]  offset;
    logic [8:0]  period;
    logic [8:0]  latency;
    logic [14:0] payload;
    logic [8:0]  count;
    logic [7:0]  id;
  } flow_t;

  typedef struct {
    status_t     status;
    logic [7:0]  left_slot;
    logic [7:0]  right_slot;
    logic [5:0]  bottom_row;
    logic [6:0]  rect_height;
    logic [7:0]  echo_id;
  } placement_t;

  logic clk, rst_n, start, busy;
  logic        in_kind;
  logic [7:0]  in_flow_offset;
  logic [8:0]  in_flow_period, in_flow_latency, in_packet_count;
  logic [14:0] in_flow_payload;
  logic [7:0]  in_flow_id;
  logic        out_valid;
  logic [1:0]  out_status;
  logic [7:0]  out_left_slot, out_right_slot, out_echo_flow_id;
  logic [5:0]  out_bottom_row;
  logic [6:0]  out_rect_height;
  logic        psel, penable, pwrite, pready;
  logic [2:0]  paddr;
  logic [31:0] pwdata, prdata;

  periodic_rectangle_grid_placer i_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_kind(in_kind), .in_flow_offset(in_flow_offset),
    .in_flow_period(in_flow_period), .in_flow_latency(in_flow_latency),
    .in_flow_payload(in_flow_payload), .in_packet_count(in_packet_count),
    .in_flow_id(in_flow_id),
    .out_valid(out_valid), .out_status(out_status),
    .out_left_slot(out_left_slot), .out_right_slot(out_right_slot),
    .out_bottom_row(out_bottom_row), .out_rect_height(out_rect_height),
    .out_echo_flow_id(out_echo_flow_id),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // predictor state
  logic [63:0] grid_model [256];
  logic        halt_model;
  int          slots_cfg, pilots_cfg;

  placement_t expected_q[$];
  int         error_count;
  int         idle_pct;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("simulation failed");
    $finish;
  end

  function automatic logic [63:0] rows_of(int bottom, int height);
    if (height == 0 || bottom >= 64) return 64'd0;
    if (height >= 64) return {64{1'b1}} << bottom;
    return ((64'd1 << height) - 64'd1) << bottom;
  endfunction

  function automatic bit copies_free(int left, int width, logic [63:0] rows,
                                     int period, int copies);
    int slots, l;
    slots = (slots_cfg > 256) ? 256 : slots_cfg;
    if (rows == 64'd0) return 1'b1;
    for (int k = 0; k < copies; k++) begin
      l = left + period * k;
      if (l + width > slots) return 1'b0;
      for (int c = l; c < l + width; c++)
        if ((grid_model[c] & rows) != 64'd0) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic placement_t place_flow(flow_t f);
    placement_t r;
    int copies, pilots, last, wmax, best_top, hgt, top, pay, lat, per;
    int best_left, best_w, best_b, best_h;
    bit found, done;
    logic [63:0] rows;
    r = '{ST_PLACED, 8'd0, 8'd0, 6'd0, 7'd0, f.id};
    if (!f.kind) begin
      foreach (grid_model[i]) grid_model[i] = 64'd0;
      halt_model = 1'b0;
      r.status = ST_CLEARED;
      return r;
    end
    if (halt_model) begin
      r.status = ST_SKIPPED;
      return r;
    end
    pay = f.payload;
    lat = f.latency;
    per = f.period;
    copies = (per == 0 && f.count > 0) ? 1 : int'(f.count);
    found = 1'b0;
    best_left = 0; best_w = 0; best_b = 0; best_h = 0;
    if (lat != 0 && copies != 0) begin
      pilots = (pilots_cfg > 64) ? 64 : pilots_cfg;
      last = int'(f.offset) + lat - 1;
      wmax = (pay <= lat && pay != 0) ? pay : lat;
      best_top = NO_TOP;
      for (int w = 1; w <= wmax; w++) begin
        hgt = (pay + w - 1) / w;
        done = 1'b0;
        for (int b = 0; b < pilots && !done; b++) begin
          top = b + hgt;
          if (top > pilots && hgt != 0) break;
          if (top >= best_top) break;
          for (int o = last - w + 1; o >= int'(f.offset); o--) begin
            if (copies_free(o, w, rows_of(b, hgt), per, copies)) begin
              best_top = top;
              found = 1'b1;
              best_left = o; best_w = w; best_b = b; best_h = hgt;
              done = 1'b1;
              break;
            end
          end
        end
      end
    end
    if (!found) begin
      halt_model = 1'b1;
      r.status = ST_NOROOM;
      return r;
    end
    rows = rows_of(best_b, best_h);
    if (rows != 64'd0)
      for (int k = 0; k < copies; k++)
        for (int c = best_left + per * k; c < best_left + per * k + best_w && c < 256; c++)
          grid_model[c] |= rows;
    r.left_slot   = best_left[7:0];
    r.right_slot  = 8'(best_left + best_w - 1);
    r.bottom_row  = best_b[5:0];
    r.rect_height = best_h[6:0];
    return r;
  endfunction

  function automatic void add_expected(placement_t p);
    expected_q.insert(expected_q.size(), p);
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  always @(posedge clk) begin
    placement_t e;
    if (rst_n && out_valid) begin
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected transaction, status", out_status, -1);
      end else begin
        e = expected_q.pop_front();
        if (out_status != e.status) report_mismatch("status", out_status, e.status);
        if (out_left_slot != e.left_slot)
          report_mismatch("left_slot", out_left_slot, e.left_slot);
        if (out_right_slot != e.right_slot)
          report_mismatch("right_slot", out_right_slot, e.right_slot);
        if (out_bottom_row != e.bottom_row)
          report_mismatch("bottom_row", out_bottom_row, e.bottom_row);
        if (out_rect_height != e.rect_height)
          report_mismatch("rect_height", out_rect_height, e.rect_height);
        if (out_echo_flow_id != e.echo_id)
          report_mismatch("echo_flow_id", out_echo_flow_id, e.echo_id);
      end
    end
  end

  // called at a rising edge; returns at the edge that took the transaction, or after a random idle gap
  task automatic send_flow(flow_t f);
    start           <= 1'b1;
    in_kind         <= f.kind;
    in_flow_offset  <= f.offset;
    in_flow_period  <= f.period;
    in_flow_latency <= f.latency;
    in_flow_payload <= f.payload;
    in_packet_count <= f.count;
    in_flow_id      <= f.id;
    do @(posedge clk); while (busy);
    add_expected(place_flow(f));
    if ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task automatic send(bit kind, int offset, int period, int latency, int payload,
                      int count);
    flow_t f;
    f = '{kind, offset[7:0], period[8:0], latency[8:0], payload[14:0], count[8:0],
          8'($urandom)};
    send_flow(f);
  endtask

  task automatic drain;
    start <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] addr, int value);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= addr;
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    if (addr == ADDR_SLOTS) slots_cfg = value & 'h1FF;
    else pilots_cfg = value & 'h7F;
  endtask

  task automatic set_grid(int slots, int pilots);
    drain();
    write_reg(ADDR_SLOTS, slots);
    write_reg(ADDR_PILOTS, pilots);
  endtask

  task automatic test_special_cases;
    idle_pct = 0;
    send(0, 0, 0, 0, 0, 0);
    send(1, 0, 1, 1, 1, 1);
    send(1, 10, 4, 3, 0, 2);
    send(1, 5, 8, 4, 6, 3);
    send(1, 0, 1, 0, 4, 1);
    send(1, 0, 1, 4, 4, 1);
    send(0, 0, 0, 0, 0, 0);
    send(1, 3, 5, 4, 2, 0);
    send(0, 0, 0, 0, 0, 0);
    send(1, 20, 0, 3, 5, 7);
    send(1, 0, 511, 2, 2, 2);
  endtask

  task automatic test_extremes;
    send(0, 0, 0, 0, 0, 0);
    send(1, 255, 1, 1, 64, 1);
    send(1, 0, 256, 511, 16384, 256);
    send(0, 0, 0, 0, 0, 0);
    send(1, 0, 0, 511, 16384, 256);
    send(1, 128, 256, 256, 32767, 1);
    send(0, 0, 0, 0, 0, 0);
    send(1, 255, 0, 1, 0, 511);
  endtask

  task automatic test_tiny_grid;
    set_grid(1, 1);
    send(0, 0, 0, 0, 0, 0);
    send(1, 0, 1, 1, 1, 3);
    send(0, 0, 0, 0, 0, 0);
    send(1, 0, 0, 2, 1, 1);
    set_grid(0, 0);
    send(0, 0, 0, 0, 0, 0);
    send(1, 0, 1, 1, 0, 1);
  endtask

  task automatic test_random(int slots, int pilots, int pct, int n_items, bit pause);
    int s;
    set_grid(slots, pilots);
    idle_pct = pct;
    s = (slots_cfg > 256) ? 256 : ((slots_cfg == 0) ? 1 : slots_cfg);
    send(0, 0, 0, 0, 0, 0);
    for (int i = 0; i < n_items; i++) begin
      if (pause && i == n_items / 2) drain();
      if ($urandom_range(0, 99) < 10)
        send(0, $urandom, $urandom, $urandom, $urandom, $urandom);
      else
        send(1, ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) : $urandom_range(0, s - 1),
             $urandom_range(0, s), $urandom_range(1, 10), $urandom_range(0, 40),
             $urandom_range(1, 4));
    end
  endtask

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_kind = 1'b0;
    in_flow_offset = '0;
    in_flow_period = '0;
    in_flow_latency = '0;
    in_flow_payload = '0;
    in_packet_count = '0;
    in_flow_id = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    error_count = 0;
    idle_pct = 0;
    foreach (grid_model[i]) grid_model[i] = 64'd0;
    halt_model = 1'b0;
    slots_cfg = 256;
    pilots_cfg = 64;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_special_cases();
    test_extremes();
    test_tiny_grid();
    test_random(32, 16, 0, 22, 1'b0);
    test_random(256, 64, 69, 22, 1'b1);
    test_random(8, 4, 23, 22, 1'b0);
    test_random(511, 127, 69, 22, 1'b0);
    test_random(48, 8, 0, 22, 1'b0);

    drain();
    repeat (50) @(posedge clk);
    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
`default_nettype wire

// ----- sim.f -----
+incdir+rtl/core
rtl/core/prgp_pkg.sv
rtl/core/prgp_ram.sv
rtl/core/prgp_div.sv
rtl/core/prgp_dp.sv
rtl/core/prgp_ctrl.sv
rtl/core/periodic_rectangle_grid_placer.sv
tb/periodic_rectangle_grid_placer_tb.sv
